// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam logic [1:0] REG_MIN_LOG = 2'd0;
  localparam logic [1:0] REG_LEVELS = 2'd1;
  localparam logic [1:0] REG_HEADER = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SPLIT,
    ST_FREE_REC,
    ST_FREE_CHECK,
    ST_MERGE_RD,
    ST_MERGE_WAIT,
    ST_DONE
  } state_t;
endpackage

// ===== src/bba_bitmem.sv =====
`timescale 1ns / 1ps
module bba_bitmem #(
  parameter int Depth = 255,
  parameter int AddrW = 8,
  parameter int DataW = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy allocator over a pool of 2^(min_block_log + pool_levels - 1) bytes.
// Requests arrive on the opcode/request_bytes/free_address channel with valid and
// ready; one result per request leaves on grant_address/block_level/status with
// out_valid and out_ready. An allocate returns the smallest free block that fits,
// split down as far as the size allows; a free returns the block and merges buddies.
// The free map (one bit per tree node) and the allocation record (one entry per
// smallest block) live in single-port-read synchronous memories.
// An allocate scans nodes one at a time, lowest level first, and then does one split
// per level down; a free reads the record and then merges one buddy pair per step.
// One node is examined per memory read round trip. Requests are handled one at a
// time.
// After reset and after a write to registers 0 to 2, a clearing pass (one node and,
// while any is left, one record a cycle) runs before the first request is accepted.
// When the receiver stalls, the result is held in the output register and the next
// request is taken only once it has been delivered.
module buddy_block_allocator #(
  parameter int LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [23:0] request_bytes,
  input  logic [22:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] grant_address,
  output logic [2:0]  block_level,
  output logic [1:0]  status
);
  localparam int NodeCount = (1 << LEVELS) - 1;
  localparam int SlotCount = 1 << (LEVELS - 1);
  localparam int NodeW = LEVELS;
  localparam int SlotW = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int LvlW = $clog2(LEVELS + 1);
  localparam int RecW = $clog2(LEVELS + 1);

  logic [4:0] min_block_log;
  logic [3:0] pool_levels;
  logic [6:0] header_bytes;

  bba_pkg::state_t state, state_next;

  logic [4:0] m_eff;
  logic [LvlW-1:0] p_eff;
  always_comb begin
    if (min_block_log < 5'd4) m_eff = 5'd4;
    else if (min_block_log > 5'd16) m_eff = 5'd16;
    else m_eff = min_block_log;
    if (pool_levels == 4'd0) p_eff = LvlW'(1);
    else if (32'(pool_levels) > LEVELS) p_eff = LvlW'(LEVELS);
    else p_eff = LvlW'(pool_levels);
  end

  logic fm_we, fm_wdata, fm_rdata;
  logic [NodeW-1:0] fm_waddr, fm_raddr;
  logic ar_we;
  logic [RecW-1:0] ar_wdata, ar_rdata;
  logic [SlotW-1:0] ar_waddr, ar_raddr;

  bba_bitmem #(.Depth(NodeCount), .AddrW(NodeW), .DataW(1)) u_free_map (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );
  bba_bitmem #(.Depth(SlotCount), .AddrW(SlotW), .DataW(RecW)) u_alloc_rec (
    .clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(ar_wdata),
    .raddr(ar_raddr), .rdata(ar_rdata)
  );

  logic [24:0]      size;
  logic [LvlW-1:0]  lvl;
  logic [LvlW-1:0]  depth;
  logic [NodeW-1:0] pos;
  logic [SlotW-1:0] slot;
  logic [NodeW:0]   clr;
  logic             cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == bba_pkg::REG_MIN_LOG ||
                              cfg_index == bba_pkg::REG_LEVELS ||
                              cfg_index == bba_pkg::REG_HEADER);

  function automatic logic [NodeW-1:0] node_of(input logic [LvlW-1:0] d,
                                                input logic [NodeW-1:0] p);
    logic [NodeW:0] base;
    base = (NodeW+1)'(((NodeW+1)'(1) << d) - 1'b1);
    return NodeW'(base + (NodeW+1)'(p));
  endfunction

  logic [39:0] blk_bytes, half_bytes;
  assign blk_bytes = 40'd1 << (6'(m_eff) + 6'(lvl));
  assign half_bytes = 40'd1 << (6'(m_eff) + 6'(lvl) - 6'd1);

  logic [LvlW-1:0] top_depth;
  assign top_depth = p_eff - LvlW'(1) - lvl;
  logic [NodeW-1:0] row_last;
  assign row_last = NodeW'(((NodeW+1)'(1) << top_depth) - 1'b1);

  logic [23:0] off_a;
  logic bad_free;
  logic [22:0] a_in;
  assign a_in = free_address;
  assign off_a = 24'(a_in) - 24'(header_bytes);
  always_comb begin
    bad_free = 1'b0;
    if (a_in < 23'(header_bytes)) bad_free = 1'b1;
    else if ((off_a & ((24'd1 << m_eff) - 24'd1)) != 24'd0) bad_free = 1'b1;
    else if ((off_a >> m_eff) >= (24'd1 << (p_eff - LvlW'(1)))) bad_free = 1'b1;
  end

  logic [22:0] res_addr;
  logic [2:0]  res_lvl;
  logic [1:0]  res_status;

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::ST_CLEAR: if (clr == (NodeW+1)'(NodeCount - 1)) state_next = bba_pkg::ST_IDLE;
      bba_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (opcode == bba_pkg::OP_ALLOC) state_next = bba_pkg::ST_SCAN;
          else if (bad_free) state_next = bba_pkg::ST_DONE;
          else state_next = bba_pkg::ST_FREE_REC;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (lvl >= p_eff) state_next = bba_pkg::ST_DONE;
        else if (blk_bytes >= 40'(size)) state_next = bba_pkg::ST_SCAN_WAIT;
      end
      bba_pkg::ST_SCAN_WAIT: begin
        if (fm_rdata) state_next = bba_pkg::ST_SPLIT;
        else state_next = bba_pkg::ST_SCAN;
      end
      bba_pkg::ST_SPLIT: begin
        if (!(lvl > LvlW'(0) && 40'(size) <= half_bytes)) state_next = bba_pkg::ST_DONE;
      end
      bba_pkg::ST_FREE_REC: state_next = bba_pkg::ST_FREE_CHECK;
      bba_pkg::ST_FREE_CHECK: begin
        if (ar_rdata == RecW'(0) || ar_rdata > RecW'(p_eff)) state_next = bba_pkg::ST_DONE;
        else state_next = bba_pkg::ST_MERGE_RD;
      end
      bba_pkg::ST_MERGE_RD: begin
        if (depth == LvlW'(0)) state_next = bba_pkg::ST_DONE;
        else state_next = bba_pkg::ST_MERGE_WAIT;
      end
      bba_pkg::ST_MERGE_WAIT: begin
        if (fm_rdata) state_next = bba_pkg::ST_MERGE_RD;
        else state_next = bba_pkg::ST_DONE;
      end
      bba_pkg::ST_DONE: if (out_ready || !out_valid) state_next = bba_pkg::ST_IDLE;
      default: state_next = bba_pkg::ST_CLEAR;
    endcase
    if (cfg_hit) state_next = bba_pkg::ST_CLEAR;
  end

  always_comb begin
    fm_we = 1'b0;
    fm_waddr = '0;
    fm_wdata = 1'b0;
    fm_raddr = node_of(top_depth, pos);
    ar_we = 1'b0;
    ar_waddr = slot;
    ar_wdata = '0;
    ar_raddr = slot;
    in_ready = (state == bba_pkg::ST_IDLE) && !out_valid;
    case (state)
      bba_pkg::ST_CLEAR: begin
        fm_we = 1'b1;
        fm_waddr = clr[NodeW-1:0];
        fm_wdata = (clr == '0);
        ar_we = (clr < (NodeW+1)'(SlotCount));
        ar_waddr = clr[SlotW-1:0];
      end
      bba_pkg::ST_SCAN_WAIT: begin
        if (fm_rdata) begin
          fm_we = 1'b1;
          fm_waddr = node_of(top_depth, pos);
        end
      end
      bba_pkg::ST_SPLIT: begin
        if (lvl > LvlW'(0) && 40'(size) <= half_bytes) begin
          fm_we = 1'b1;
          fm_waddr = node_of(depth + LvlW'(1), NodeW'({pos, 1'b1}));
          fm_wdata = 1'b1;
        end else begin
          ar_we = 1'b1;
          ar_waddr = SlotW'(pos << lvl);
          ar_wdata = RecW'(lvl) + RecW'(1);
        end
      end
      bba_pkg::ST_FREE_CHECK: begin
        if (!(ar_rdata == RecW'(0) || ar_rdata > RecW'(p_eff))) begin
          ar_we = 1'b1;
          ar_wdata = '0;
        end
      end
      bba_pkg::ST_MERGE_RD: begin
        fm_raddr = node_of(depth, pos ^ NodeW'(1));
        if (depth == LvlW'(0)) begin
          fm_we = 1'b1;
          fm_waddr = node_of(depth, pos);
          fm_wdata = 1'b1;
        end
      end
      bba_pkg::ST_MERGE_WAIT: begin
        fm_we = 1'b1;
        if (fm_rdata) begin
          fm_waddr = node_of(depth, pos ^ NodeW'(1));
          fm_wdata = 1'b0;
        end else begin
          fm_waddr = node_of(depth, pos);
          fm_wdata = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      min_block_log <= 5'd5;
      pool_levels <= 4'd8;
      header_bytes <= 7'd16;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          bba_pkg::REG_MIN_LOG: min_block_log <= cfg_data[4:0];
          bba_pkg::REG_LEVELS:  pool_levels <= cfg_data[3:0];
          bba_pkg::REG_HEADER:  header_bytes <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        clr <= '0;
      end else if (state == bba_pkg::ST_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (state == bba_pkg::ST_DONE && (out_ready || !out_valid)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::ST_IDLE: begin
        size <= 25'(request_bytes) + 25'(header_bytes);
        lvl <= '0;
        pos <= '0;
        slot <= SlotW'(off_a >> m_eff);
        res_addr <= '0;
        res_lvl <= '0;
        res_status <= (opcode == bba_pkg::OP_FREE && bad_free) ?
                      bba_pkg::STATUS_BAD_FREE : bba_pkg::STATUS_OK;
      end
      bba_pkg::ST_SCAN: begin
        if (lvl >= p_eff) res_status <= bba_pkg::STATUS_NO_FIT;
        else if (blk_bytes < 40'(size)) lvl <= lvl + LvlW'(1);
        depth <= top_depth;
      end
      bba_pkg::ST_SCAN_WAIT: begin
        if (!fm_rdata) begin
          if (pos == row_last) begin
            pos <= '0;
            lvl <= lvl + LvlW'(1);
          end else begin
            pos <= pos + NodeW'(1);
          end
        end
      end
      bba_pkg::ST_SPLIT: begin
        if (lvl > LvlW'(0) && 40'(size) <= half_bytes) begin
          lvl <= lvl - LvlW'(1);
          depth <= depth + LvlW'(1);
          pos <= NodeW'({pos, 1'b0});
        end else begin
          res_addr <= 23'((40'(pos) << (6'(m_eff) + 6'(lvl))) + 40'(header_bytes));
          res_lvl <= 3'(lvl);
        end
      end
      bba_pkg::ST_FREE_CHECK: begin
        if (ar_rdata == RecW'(0) || ar_rdata > RecW'(p_eff)) begin
          res_status <= bba_pkg::STATUS_BAD_FREE;
        end else begin
          lvl <= LvlW'(ar_rdata - RecW'(1));
          res_lvl <= 3'(ar_rdata - RecW'(1));
          pos <= NodeW'(slot >> (ar_rdata - RecW'(1)));
          depth <= p_eff - LvlW'(ar_rdata);
        end
      end
      bba_pkg::ST_MERGE_WAIT: begin
        if (fm_rdata) begin
          pos <= pos >> 1;
          depth <= depth - LvlW'(1);
        end
      end
      bba_pkg::ST_DONE: begin
        if (out_ready || !out_valid) begin
          grant_address <= res_addr;
          block_level <= res_lvl;
          status <= res_status;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/bba_checker.sv =====
`timescale 1ns / 1ps
module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [22:0] grant_address,
  input logic [2:0]  block_level,
  input logic [1:0]  status
);
  a_no_valid_in_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == bba_pkg::STATUS_OK || status == bba_pkg::STATUS_NO_FIT ||
                   status == bba_pkg::STATUS_BAD_FREE))
    else $error("undefined status");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bba_pkg::STATUS_OK) |-> (grant_address == '0 && block_level == '0))
    else $error("failed request carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(grant_address) && $stable(status)))
    else $error("stalled result changed");
  a_one_outstanding: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .grant_address(grant_address),
  .block_level(block_level), .status(status)
);
